@@ hdl/rti_pkg.sv @@
package rti_pkg;

  // Width of every packed vector port.
  localparam int FIELD_W = 48;

  // Default width of one signed vector component.
  localparam int COORD_WIDTH_DEF = 16;

  // Register stages from input acceptance to the output register.
  localparam int NUM_STAGES = 7;

endpackage

@@ hdl/ray_triangle_intersect.sv @@
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------------
// input    | in_valid / in_stall    | ray_origin, ray_direction, vertex_zero,
//          |                        | vertex_one, vertex_two (packed x,y,z)
// output   | out_valid / out_stall  | hit, degenerate
//
// One item enters per cycle while in_stall is low. Its result is presented once
// it has passed through all NUM_STAGES stage registers. The depth is set by the
// chain of two multiplications (cross products, then the dot products split
// into partial products), each followed by its own add stage.
// Reset (rst, synchronous) clears only the stage valid bits.
// A stall holds only the stages that are occupied; bubbles ahead of a stalled
// result still close up, and in_stall rises only when all stages are full.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] ray_origin,
  input  logic [FIELD_W-1:0] ray_direction,
  input  logic [FIELD_W-1:0] vertex_zero,
  input  logic [FIELD_W-1:0] vertex_one,
  input  logic [FIELD_W-1:0] vertex_two,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               degenerate
);

  // Width plan. Edge and offset vectors need one bit more than a component.
  // Cross products of such vectors fit in CW bits; the second multiplication
  // splits the cross product into a low unsigned part of L bits and a signed
  // high part so that no single multiplier grows past 17 by 19 bits at the default width.
  // Every determinant fits in DW bits.
  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int MW  = 2 * W + 2;
  localparam int CW  = 2 * W + 3;
  localparam int L   = W + 2;
  localparam int HW  = CW - L;
  localparam int LPW = EW + L + 1;
  localparam int HPW = EW + HW;
  localparam int DW  = 3 * W + 4;
  localparam int SW  = DW + 1;
  localparam int PW  = (3 * W > FIELD_W) ? 3 * W : FIELD_W;

  // Stage valid bits and load enables; the top enable is the output channel.
  logic [NUM_STAGES:1]   vld;
  logic [NUM_STAGES+1:1] en;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en[NUM_STAGES+1] = !out_stall;
    for (int i = NUM_STAGES; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Unpacking. Bits of a port above the three components are ignored, and
  // components that reach past the port read the missing bits as zero.
  logic [PW-1:0] org_w, dir_w, v0_w, v1_w, v2_w;

  assign org_w = PW'(ray_origin);
  assign dir_w = PW'(ray_direction);
  assign v0_w  = PW'(vertex_zero);
  assign v1_w  = PW'(vertex_one);
  assign v2_w  = PW'(vertex_two);

  logic signed [W-1:0] org_c [3];
  logic signed [W-1:0] dir_c [3];
  logic signed [W-1:0] v0_c  [3];
  logic signed [W-1:0] v1_c  [3];
  logic signed [W-1:0] v2_c  [3];

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign org_c[k] = org_w[k*W +: W];
    assign dir_c[k] = dir_w[k*W +: W];
    assign v0_c[k]  = v0_w[k*W +: W];
    assign v1_c[k]  = v1_w[k*W +: W];
    assign v2_c[k]  = v2_w[k*W +: W];
  end

  // Stage 1: edges e1 = v1 - v0, e2 = v2 - v0, offset s = origin - v0.
  logic signed [EW-1:0] e1_1 [3];
  logic signed [EW-1:0] e2_1 [3];
  logic signed [EW-1:0] s_1  [3];
  logic signed [EW-1:0] d_1  [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        e1_1[k] <= EW'(v1_c[k]) - EW'(v0_c[k]);
        e2_1[k] <= EW'(v2_c[k]) - EW'(v0_c[k]);
        s_1[k]  <= EW'(org_c[k]) - EW'(v0_c[k]);
        d_1[k]  <= EW'(dir_c[k]);
      end
    end
  end

  // Stage 2: the twelve products of the cross products p = e2 x dir and
  // q = s x e1. Component k takes the products of the other two axes.
  logic signed [MW-1:0] pa_2 [3];
  logic signed [MW-1:0] pb_2 [3];
  logic signed [MW-1:0] qa_2 [3];
  logic signed [MW-1:0] qb_2 [3];
  logic signed [EW-1:0] e1_2 [3];
  logic signed [EW-1:0] e2_2 [3];
  logic signed [EW-1:0] s_2  [3];
  logic signed [EW-1:0] d_2  [3];

  for (genvar k = 0; k < 3; k++) begin : g_cross_mul
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    always_ff @(posedge clk) begin
      if (en[2]) begin
        pa_2[k] <= MW'(e2_1[K1]) * MW'(d_1[K2]);
        pb_2[k] <= MW'(e2_1[K2]) * MW'(d_1[K1]);
        qa_2[k] <= MW'(s_1[K1]) * MW'(e1_1[K2]);
        qb_2[k] <= MW'(s_1[K2]) * MW'(e1_1[K1]);
        e1_2[k] <= e1_1[k];
        e2_2[k] <= e2_1[k];
        s_2[k]  <= s_1[k];
        d_2[k]  <= d_1[k];
      end
    end
  end

  // Stage 3: cross product components.
  logic signed [CW-1:0] p_3  [3];
  logic signed [CW-1:0] q_3  [3];
  logic signed [EW-1:0] e1_3 [3];
  logic signed [EW-1:0] e2_3 [3];
  logic signed [EW-1:0] s_3  [3];
  logic signed [EW-1:0] d_3  [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        p_3[k]  <= CW'(pa_2[k]) - CW'(pb_2[k]);
        q_3[k]  <= CW'(qa_2[k]) - CW'(qb_2[k]);
        e1_3[k] <= e1_2[k];
        e2_3[k] <= e2_2[k];
        s_3[k]  <= s_2[k];
        d_3[k]  <= d_2[k];
      end
    end
  end

  // Dot products. Row 0 is D = e1.p, row 1 is Nu = s.p, row 2 is dir.q
  // (which is -Nv) and row 3 is e2.q (which is -Nt).
  logic signed [EW-1:0] opa [4][3];
  logic signed [CW-1:0] opb [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[0][k] = e1_3[k];
      opb[0][k] = p_3[k];
      opa[1][k] = s_3[k];
      opb[1][k] = p_3[k];
      opa[2][k] = d_3[k];
      opb[2][k] = q_3[k];
      opa[3][k] = e2_3[k];
      opb[3][k] = q_3[k];
    end
  end

  // Stage 4: partial products, low part unsigned and high part signed.
  logic signed [LPW-1:0] lo_4 [4][3];
  logic signed [HPW-1:0] hi_4 [4][3];

  for (genvar j = 0; j < 4; j++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      logic signed [L:0]    lo_op;
      logic signed [HW-1:0] hi_op;

      assign lo_op = {1'b0, opb[j][k][L-1:0]};
      assign hi_op = opb[j][k][CW-1:L];

      always_ff @(posedge clk) begin
        if (en[4]) begin
          lo_4[j][k] <= LPW'(opa[j][k]) * LPW'(lo_op);
          hi_4[j][k] <= HPW'(opa[j][k]) * HPW'(hi_op);
        end
      end
    end
  end

  // Stage 5: recombine each product term.
  logic signed [DW-1:0] term_5 [4][3];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          term_5[j][k] <= (DW'(hi_4[j][k]) <<< L) + DW'(lo_4[j][k]);
        end
      end
    end
  end

  // Stage 6: sum the three terms of each determinant.
  logic signed [DW-1:0] det_6 [4];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 4; j++) begin
        det_6[j] <= term_5[j][0] + term_5[j][1] + term_5[j][2];
      end
    end
  end

  // Stage 7: sign-corrected comparisons. With D positive the conditions are
  // Nu >= 0, dir.q <= 0, e2.q <= 0 and Nu - dir.q <= D; with D negative every
  // inequality turns around. A zero determinant is degenerate and never a hit.
  logic                 d_pos;
  logic                 d_zero;
  logic signed [SW-1:0] uv_sum;
  logic                 u_ok, v_ok, t_ok, uv_ok;
  logic                 hit_next;

  always_comb begin
    d_zero = (det_6[0] == '0);
    d_pos  = !det_6[0][DW-1];
    uv_sum = SW'(det_6[1]) - SW'(det_6[2]);
    if (d_pos) begin
      u_ok  = !det_6[1][DW-1];
      v_ok  = (det_6[2] <= 0);
      t_ok  = (det_6[3] <= 0);
      uv_ok = (uv_sum <= SW'(det_6[0]));
    end else begin
      u_ok  = (det_6[1] <= 0);
      v_ok  = !det_6[2][DW-1];
      t_ok  = !det_6[3][DW-1];
      uv_ok = (uv_sum >= SW'(det_6[0]));
    end
    hit_next = !d_zero && u_ok && v_ok && t_ok && uv_ok;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hit        <= hit_next;
      degenerate <= d_zero;
    end
  end

endmodule

@@ hdl/rti_checker.sv @@
module rti_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit,
  input logic degenerate
);

  // A result waiting under stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(degenerate))
    else $error("stalled result changed");

  // A degenerate system never reports a hit.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && degenerate))
    else $error("hit and degenerate both set");

  // Input is held back only when the pipeline is full behind a stalled result.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An empty output stage never holds the input back.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the ray/triangle intersection block.
// Items not typed in are scored by an exact integer solver kept in this file.
// A verdict is queued and compared with the next result that leaves the block.
// A short directed table covers the boundary cases of the barycentric test:
// edges, vertices, the far corner, a distance of zero, both windings and every
// way the system can collapse. After that, several hundred random items run
// through four traffic phases. Some random items are aimed at the triangle so
// that hits, misses and degenerate systems all show up in large numbers.
module testbench;
  import rti_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int PHASES = 4;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int TAIL_CYCLES = 4 * NUM_STAGES;

  // A row of the directed table either has its outcome typed in (every
  // collapsed system reads as degenerate at a glance) or is solved by the
  // bench's own solver.
  localparam bit FLAT = 1'b1;
  localparam bit SOLVE = 1'b0;

  typedef struct packed {
    logic hit;
    logic degenerate;
  } verdict_t;

  localparam verdict_t FLAT_VERDICT = '{hit: 1'b0, degenerate: 1'b1};

  typedef struct {
    logic [FIELD_W-1:0] org;
    logic [FIELD_W-1:0] dir;
    logic [FIELD_W-1:0] p0;
    logic [FIELD_W-1:0] p1;
    logic [FIELD_W-1:0] p2;
    bit                 flat;
  } probe_t;

  typedef longint triple_t [3];

  // Traffic phases: no gaps, a sparse sender, a busy receiver, then light
  // gaps on both sides.
  int idle_tbl [PHASES] = '{0, 86, 0, 11};
  int stall_tbl [PHASES] = '{0, 0, 86, 11};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] ray_origin = '0;
  logic [FIELD_W-1:0] ray_direction = '0;
  logic [FIELD_W-1:0] vertex_zero = '0;
  logic [FIELD_W-1:0] vertex_one = '0;
  logic [FIELD_W-1:0] vertex_two = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic               degenerate;

  verdict_t pending_verdicts[$];
  probe_t   probes[$];
  int       mismatches = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;

  ray_triangle_intersect #(
    .COORD_WIDTH(COORD_WIDTH_DEF)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ray_origin   (ray_origin),
    .ray_direction(ray_direction),
    .vertex_zero  (vertex_zero),
    .vertex_one   (vertex_one),
    .vertex_two   (vertex_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .degenerate   (degenerate)
  );

  always #2 clk = ~clk;

  // Packs three signed components into one vector port, x in the low bits.
  function automatic logic [FIELD_W-1:0] vec(int x, int y, int z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic probe_t row(logic [FIELD_W-1:0] org, logic [FIELD_W-1:0] dir,
                                 logic [FIELD_W-1:0] p0, logic [FIELD_W-1:0] p1,
                                 logic [FIELD_W-1:0] p2, bit flat);
    probe_t r;
    r.org = org;
    r.dir = dir;
    r.p0 = p0;
    r.p1 = p1;
    r.p2 = p2;
    r.flat = flat;
    return r;
  endfunction

  function automatic void split(input logic [FIELD_W-1:0] w, output triple_t v);
    for (int k = 0; k < 3; k++) begin
      v[k] = longint'($signed(w[k*CW +: CW]));
    end
  endfunction

  // Scalar triple product a . (b x c), exact in 64 bits for these widths.
  function automatic longint det3(triple_t a, triple_t b, triple_t c);
    return a[0] * (b[1] * c[2] - b[2] * c[1])
         + a[1] * (b[2] * c[0] - b[0] * c[2])
         + a[2] * (b[0] * c[1] - b[1] * c[0]);
  endfunction

  // Solves the barycentric system by Cramer's rule. Instead of dividing,
  // each numerator takes the sign of the determinant and is compared with
  // its magnitude, so the test is exact and boundaries count as hits.
  function automatic verdict_t intersect_verdict(logic [FIELD_W-1:0] org_w,
                                                 logic [FIELD_W-1:0] dir_w,
                                                 logic [FIELD_W-1:0] p0_w,
                                                 logic [FIELD_W-1:0] p1_w,
                                                 logic [FIELD_W-1:0] p2_w);
    triple_t  org, dir, p0, p1, p2, e1, e2, s;
    longint   dt, nu, nv, nt;
    verdict_t v;
    split(org_w, org);
    split(dir_w, dir);
    split(p0_w, p0);
    split(p1_w, p1);
    split(p2_w, p2);
    for (int k = 0; k < 3; k++) begin
      e1[k] = p1[k] - p0[k];
      e2[k] = p2[k] - p0[k];
      s[k] = org[k] - p0[k];
    end
    dt = det3(e1, e2, dir);
    v.degenerate = (dt == 0);
    v.hit = 1'b0;
    if (dt != 0) begin
      nu = det3(s, e2, dir);
      nv = det3(e1, s, dir);
      nt = -det3(e1, e2, s);
      if (dt < 0) begin
        dt = -dt;
        nu = -nu;
        nv = -nv;
        nt = -nt;
      end
      v.hit = (nu >= 0) && (nv >= 0) && (nu + nv <= dt) && (nt >= 0);
    end
    return v;
  endfunction

  // Presents one item, holding it steady until the block takes it. Gaps are
  // inserted only between items, and never in response to the stall.
  task automatic offer(input logic [FIELD_W-1:0] org, input logic [FIELD_W-1:0] dir,
                       input logic [FIELD_W-1:0] p0, input logic [FIELD_W-1:0] p1,
                       input logic [FIELD_W-1:0] p2, input verdict_t want);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ray_origin <= org;
    ray_direction <= dir;
    vertex_zero <= p0;
    vertex_one <= p1;
    vertex_two <= p2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(want);
  endtask

  // The receiver stalls at random and scores every result it accepts. The
  // stall in force at this edge is the one read here, since the new value
  // lands only after the edge.
  always @(posedge clk) begin : score_results
    verdict_t want;
    out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no item outstanding: hit=%b degenerate=%b",
                   $realtime, hit, degenerate);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (hit !== want.hit || degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: hit exp %b got %b, degenerate exp %b got %b",
                     $realtime, want.hit, hit, want.degenerate, degenerate);
          end
        end
      end
    end
  end

  initial begin : stimulus
    verdict_t           want;
    int                 cv [5][3];
    int                 wa, wb, sc, q, mode;
    logic [FIELD_W-1:0] f [5];

    // Directed table. The reference triangle lies in the z = 0 plane with
    // its right angle at the origin and legs of ten along x and y; most rays
    // fall straight along +z from below it.
    probes.push_back(row('0, '0, '0, '0, '0, FLAT));
    probes.push_back(row('1, '1, '1, '1, '1, FLAT));
    probes.push_back(row(vec(-32768, -32768, -32768), vec(-32768, -32768, -32768),
                         vec(-32768, -32768, -32768), vec(-32768, -32768, -32768),
                         vec(-32768, -32768, -32768), FLAT));
    probes.push_back(row(vec(32767, 32767, 32767), vec(32767, 32767, 32767),
                         vec(32767, 32767, 32767), vec(32767, 32767, 32767),
                         vec(32767, 32767, 32767), FLAT));
    // Interior point, then the same point behind the origin, then on it.
    probes.push_back(row(vec(1, 1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(1, 1, 5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(1, 1, 0), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    // Both legs, two corners and the hypotenuse are all inside.
    probes.push_back(row(vec(5, 0, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(0, 5, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(0, 0, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(0, 10, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(5, 5, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    // One step outside across the hypotenuse and across each leg.
    probes.push_back(row(vec(6, 5, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(-1, 1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    probes.push_back(row(vec(1, -1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    // Reversed winding gives a negative determinant.
    probes.push_back(row(vec(1, 1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(0, 10, 0),
                         vec(10, 0, 0), SOLVE));
    probes.push_back(row(vec(1, 1, 5), vec(0, 0, 1), vec(0, 0, 0), vec(0, 10, 0),
                         vec(10, 0, 0), SOLVE));
    probes.push_back(row(vec(-20, -20, -20), vec(21, 21, 20), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), SOLVE));
    // Zero direction, a direction inside the plane, two coincident vertices
    // and three collinear vertices all collapse the system.
    probes.push_back(row(vec(1, 1, -5), vec(0, 0, 0), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), FLAT));
    probes.push_back(row(vec(1, 1, -5), vec(1, 0, 0), vec(0, 0, 0), vec(10, 0, 0),
                         vec(0, 10, 0), FLAT));
    probes.push_back(row(vec(1, 1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(10, 0, 0), FLAT));
    probes.push_back(row(vec(1, 1, -5), vec(0, 0, 1), vec(0, 0, 0), vec(10, 0, 0),
                         vec(20, 0, 0), FLAT));
    // Full-range triangle: edges span the whole coordinate range.
    probes.push_back(row(vec(0, 0, -32768), vec(0, 0, 32767), vec(-32768, -32768, 0),
                         vec(32767, -32768, 0), vec(-32768, 32767, 0), SOLVE));
    probes.push_back(row(vec(-100, -100, 32767), vec(0, 0, -32768), vec(-32768, -32768, 0),
                         vec(32767, -32768, 0), vec(-32768, 32767, 0), SOLVE));
    probes.push_back(row(vec(32767, 32767, -32768), vec(0, 0, 1), vec(-32768, -32768, 0),
                         vec(32767, -32768, 0), vec(-32768, 32767, 0), SOLVE));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      want = probes[i].flat ? FLAT_VERDICT
                            : intersect_verdict(probes[i].org, probes[i].dir, probes[i].p0,
                                                probes[i].p1, probes[i].p2);
      offer(probes[i].org, probes[i].dir, probes[i].p0, probes[i].p1, probes[i].p2, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // The sender holds off until the pipeline is empty at every phase change.
      in_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
      idle_pct = idle_tbl[ph];
      stall_pct = stall_tbl[ph];

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode = $urandom_range(0, 9);
        for (int j = 0; j < 5; j++) begin
          for (int k = 0; k < 3; k++) begin
            if (mode < 3) begin
              // Raw random components toggle every bit of every port.
              cv[j][k] = int'($urandom_range(0, 65535)) - 32768;
            end else if (mode < 4) begin
              case ($urandom_range(0, 4))
                0: cv[j][k] = -32768;
                1: cv[j][k] = 32767;
                2: cv[j][k] = 0;
                3: cv[j][k] = -1;
                default: cv[j][k] = 1;
              endcase
            end else if (mode < 6) begin
              // A tiny grid makes edge touches and flat systems common.
              cv[j][k] = int'($urandom_range(0, 16)) - 8;
            end else begin
              cv[j][k] = int'($urandom_range(0, 4000)) - 2000;
            end
          end
        end
        if (mode >= 6) begin
          // Aim the ray at a point of the triangle given by weights in
          // sixteenths, sometimes pointing it the opposite way.
          wa = $urandom_range(0, 16);
          wb = $urandom_range(0, 16 - wa);
          sc = $urandom_range(1, 4);
          if ($urandom_range(0, 4) == 0) sc = -sc;
          for (int k = 0; k < 3; k++) begin
            q = cv[2][k] + (wa * (cv[3][k] - cv[2][k]) + wb * (cv[4][k] - cv[2][k])) / 16;
            cv[1][k] = (q - cv[0][k]) * sc;
          end
        end
        for (int j = 0; j < 5; j++) begin
          f[j] = vec(cv[j][0], cv[j][1], cv[j][2]);
        end
        offer(f[0], f[1], f[2], f[3], f[4], intersect_verdict(f[0], f[1], f[2], f[3], f[4]));
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // Idle time after the drain catches any result that should not exist.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ray_triangle_intersect: match");
    end else begin
      $display("ray_triangle_intersect: mismatch");
    end
    $finish;
  end

  // Ends a run that never finishes and reports it as a mismatch.
  initial begin : watchdog
    #2_000_000;
    $display("ray_triangle_intersect: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rti_pkg.sv
hdl/ray_triangle_intersect.sv
hdl/rti_checker.sv
verif/testbench.sv
